@@ hdl/fcull_pkg.sv @@
// Shared types and constants for the six-plane frustum culling block.
package fcull_pkg;

  localparam int NUM_PLANES = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_PLANE_NEAR   = 3'd0;
  localparam logic [2:0] REG_PLANE_FAR    = 3'd1;
  localparam logic [2:0] REG_PLANE_LEFT   = 3'd2;
  localparam logic [2:0] REG_PLANE_RIGHT  = 3'd3;
  localparam logic [2:0] REG_PLANE_TOP    = 3'd4;
  localparam logic [2:0] REG_PLANE_BOTTOM = 3'd5;

  // Query kinds carried in s_tuser.
  localparam logic REQ_SPHERE = 1'b0;
  localparam logic REQ_BOX    = 1'b1;

  localparam int COORD_W  = 20;  // signed Q15.4
  localparam int EXTENT_W = 19;  // unsigned, 4 fraction bits
  localparam int NORM_W   = 12;  // signed Q1.10
  localparam int OFFS_W   = 28;  // signed, 4 fraction bits
  localparam int PLANE_W  = 64;

  localparam int PROD_W  = COORD_W + NORM_W;       // a * cx
  localparam int REACHP_W = EXTENT_W + NORM_W;     // |a| * ex
  localparam int DIST_W  = 40;                     // dot + d * 2^10
  localparam int REACH_W = REACHP_W + 2;           // sum of three reach terms
  localparam int TEST_W  = DIST_W + 1;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 8;

  // Load enables of the pipeline registers and their valid bits.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } stage_en_t;

  typedef struct packed {
    logic v1;
    logic v2;
    logic v3;
    logic v4;
  } stage_vld_t;

endpackage

@@ hdl/fcull_ctrl.sv @@
// Valid tracking and stall control for the four-stage culling pipeline.
module fcull_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output fcull_pkg::stage_en_t   en,
  output fcull_pkg::stage_vld_t  vld
);

  fcull_pkg::stage_vld_t vld_next;

  // A stage may load when it is empty or when its contents move on.
  always_comb begin
    en.ld4 = !vld.v4 || m_tready;
    en.ld3 = !vld.v3 || en.ld4;
    en.ld2 = !vld.v2 || en.ld3;
    en.ld1 = !vld.v1 || en.ld2;

    vld_next.v1 = en.ld1 ? s_tvalid : vld.v1;
    vld_next.v2 = en.ld2 ? vld.v1   : vld.v2;
    vld_next.v3 = en.ld3 ? vld.v2   : vld.v3;
    vld_next.v4 = en.ld4 ? vld.v3   : vld.v4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign s_tready = en.ld1;
  assign m_tvalid = vld.v4;

endmodule

@@ hdl/fcull_plane.sv @@
// Datapath for one plane: products, sums, and the strict sign test.
module fcull_plane (
  input  logic                                  clk,
  input  fcull_pkg::stage_en_t                  en,
  input  logic [fcull_pkg::PLANE_W-1:0]         plane,
  input  logic signed [fcull_pkg::COORD_W-1:0]  cx,
  input  logic signed [fcull_pkg::COORD_W-1:0]  cy,
  input  logic signed [fcull_pkg::COORD_W-1:0]  cz,
  input  logic [fcull_pkg::EXTENT_W-1:0]        ex,
  input  logic [fcull_pkg::EXTENT_W-1:0]        ey,
  input  logic [fcull_pkg::EXTENT_W-1:0]        ez,
  input  logic                                  s1_is_box,
  input  logic [fcull_pkg::EXTENT_W-1:0]        s1_ex,
  output logic                                  reject
);

  logic signed [fcull_pkg::NORM_W-1:0] a, b, c;
  logic signed [fcull_pkg::OFFS_W-1:0] d;
  logic [fcull_pkg::NORM_W-1:0] a_mag, b_mag, c_mag;

  logic signed [fcull_pkg::PROD_W-1:0] ax_mul, by_mul, cz_mul;
  logic [fcull_pkg::REACHP_W-1:0]      ae_mul, be_mul, ce_mul;

  // Stage 1 registers.
  logic signed [fcull_pkg::PROD_W-1:0] ax, by, cz_p;
  logic [fcull_pkg::REACHP_W-1:0]      ae, be, ce;
  logic signed [fcull_pkg::OFFS_W-1:0] d1;

  // Stage 2 registers.
  logic signed [fcull_pkg::DIST_W-1:0] distance;
  logic [fcull_pkg::REACH_W-1:0]       margin;

  logic signed [fcull_pkg::DIST_W-1:0] distance_next;
  logic [fcull_pkg::REACH_W-1:0]       margin_next;
  logic signed [fcull_pkg::TEST_W-1:0] test;

  assign a = plane[11:0];
  assign b = plane[23:12];
  assign c = plane[35:24];
  assign d = plane[63:36];

  // The magnitude of -2048 is 2048, which still fits 12 unsigned bits.
  assign a_mag = a[fcull_pkg::NORM_W-1] ? fcull_pkg::NORM_W'(-a) : fcull_pkg::NORM_W'(a);
  assign b_mag = b[fcull_pkg::NORM_W-1] ? fcull_pkg::NORM_W'(-b) : fcull_pkg::NORM_W'(b);
  assign c_mag = c[fcull_pkg::NORM_W-1] ? fcull_pkg::NORM_W'(-c) : fcull_pkg::NORM_W'(c);

  assign ax_mul = a * cx;
  assign by_mul = b * cy;
  assign cz_mul = c * cz;
  assign ae_mul = a_mag * ex;
  assign be_mul = b_mag * ey;
  assign ce_mul = c_mag * ez;

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      ax   <= ax_mul;
      by   <= by_mul;
      cz_p <= cz_mul;
      ae   <= ae_mul;
      be   <= be_mul;
      ce   <= ce_mul;
      d1   <= d;
    end
  end

  // Everything carries 14 fraction bits, so d is scaled up by 2^10.
  always_comb begin
    distance_next = fcull_pkg::DIST_W'(ax) + fcull_pkg::DIST_W'(by)
                  + fcull_pkg::DIST_W'(cz_p) + fcull_pkg::DIST_W'($signed({d1, 10'b0}));
    if (s1_is_box == fcull_pkg::REQ_BOX) begin
      margin_next = fcull_pkg::REACH_W'(ae) + fcull_pkg::REACH_W'(be)
                  + fcull_pkg::REACH_W'(ce);
    end else begin
      margin_next = fcull_pkg::REACH_W'({s1_ex, 10'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      distance <= distance_next;
      margin   <= margin_next;
    end
  end

  // Rejected when distance plus margin is strictly negative.
  assign test = fcull_pkg::TEST_W'(distance) + $signed({1'b0, margin});

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      reject <= test[fcull_pkg::TEST_W-1];
    end
  end

endmodule

@@ hdl/frustum_cull_test.sv @@
// Top level of the six-plane frustum culling block.
// Each query is tested against six planes (near, far, left, right, top, bottom)
// loaded through the configuration port; s_tuser selects a sphere test (0) or
// a box test (1), and the single result bit is 1 when no plane rejects it.
// The block takes one query per clock while the output side is not stalled;
// the answer passes through one stage of multipliers, one of sums, one of sign
// tests and the output register that combines the six planes. Plane writes
// must be made while no query is in flight; all planes reset to zero, which
// makes every query visible.
module frustum_cull_test (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [fcull_pkg::PLANE_W-1:0]       cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // center_x, center_y, center_z, extent_x, extent_y, extent_z, zero fill
  input  logic [fcull_pkg::IN_TDATA_W-1:0]    s_tdata,
  // req_type
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // visible, zero fill
  output logic [fcull_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  fcull_pkg::stage_en_t  en;
  fcull_pkg::stage_vld_t vld;

  logic [fcull_pkg::PLANE_W-1:0] planes [fcull_pkg::NUM_PLANES];
  logic [fcull_pkg::NUM_PLANES-1:0] rejects;

  logic signed [fcull_pkg::COORD_W-1:0] cx, cy, cz;
  logic [fcull_pkg::EXTENT_W-1:0]       ex, ey, ez;
  logic                                 s1_is_box;
  logic [fcull_pkg::EXTENT_W-1:0]       s1_ex;
  logic                                 visible;

  assign cx = s_tdata[19:0];
  assign cy = s_tdata[39:20];
  assign cz = s_tdata[59:40];
  assign ex = s_tdata[78:60];
  assign ey = s_tdata[97:79];
  assign ez = s_tdata[116:98];

  fcull_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .en       (en),
    .vld      (vld)
  );

  // Indexes above the bottom plane match no register and are dropped.
  for (genvar g = 0; g < fcull_pkg::NUM_PLANES; g++) begin : g_plane
    always_ff @(posedge clk) begin
      if (rst) begin
        planes[g] <= '0;
      end else if (cfg_we && cfg_index == 3'(g)) begin
        planes[g] <= cfg_data;
      end
    end

    fcull_plane u_plane (
      .clk       (clk),
      .en        (en),
      .plane     (planes[g]),
      .cx        (cx),
      .cy        (cy),
      .cz        (cz),
      .ex        (ex),
      .ey        (ey),
      .ez        (ez),
      .s1_is_box (s1_is_box),
      .s1_ex     (s1_ex),
      .reject    (rejects[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      s1_is_box <= s_tuser;
      s1_ex     <= ex;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld4) begin
      visible <= ~|rejects;
    end
  end

  assign m_tdata = {{(fcull_pkg::OUT_TDATA_W-1){1'b0}}, visible};

  // An accepting sink never stalls the source side.
  a_ready_follows_sink: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while the output side accepts");

  // A result appears only when the compare stage held an item.
  a_result_from_stage3: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vld.v3))
    else $error("result appeared without an item in the compare stage");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !vld.v3) |=> !m_tvalid)
    else $error("result repeated after transfer");

endmodule
